/* rtl/dht_pkg.sv */
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants, codes and types of the single-wire sensor frame decoder.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int PULSES_PER_FRAME = 42;
  localparam int IDX_W            = $clog2(PULSES_PER_FRAME);
  localparam int DUR_W            = 15;
  localparam int CFG_IDX_W        = 8;
  localparam int QUEUE_DEPTH      = 2;

  // first pulse that carries data; the two before it are the sensor response
  localparam int DATA_FIRST = 2;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PULSES_PER_FRAME - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = CFG_IDX_W'(3);

  localparam logic [DUR_W-1:0] ZERO_MIN_RESET = DUR_W'(20);
  localparam logic [DUR_W-1:0] ZERO_MAX_RESET = DUR_W'(30);
  localparam logic [DUR_W-1:0] ONE_MIN_RESET  = DUR_W'(70);
  localparam logic [DUR_W-1:0] ONE_MAX_RESET  = DUR_W'(80);

  // what a pulse does to the stored bit at its position
  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_ZERO,
    ACT_ONE
  } bit_act_t;

  typedef struct packed {
    logic     start;
    bit_act_t act;
  } pulse_cmd_t;

endpackage

/* rtl/dht_front.sv */
// ----------------------------------------------------------------------------
// dht_front
// Holds the window registers and classifies each pulse record into a command.
// ----------------------------------------------------------------------------
module dht_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dht_pkg::DUR_W-1:0]      cfg_data,
  input  logic                           frame_start,
  input  logic                           first_level,
  input  logic [dht_pkg::DUR_W-1:0]      first_duration,
  input  logic                           second_level,
  input  logic [dht_pkg::DUR_W-1:0]      second_duration,
  output dht_pkg::pulse_cmd_t            cmd
);
  import dht_pkg::*;

  logic [DUR_W-1:0] zero_min;
  logic [DUR_W-1:0] zero_max;
  logic [DUR_W-1:0] one_min;
  logic [DUR_W-1:0] one_max;

  logic [DUR_W-1:0] dur;
  logic             have_high;
  logic             in_zero;
  logic             in_one;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_min <= ZERO_MIN_RESET;
      zero_max <= ZERO_MAX_RESET;
      one_min  <= ONE_MIN_RESET;
      one_max  <= ONE_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZERO_MIN: zero_min <= cfg_data;
        REG_ZERO_MAX: zero_max <= cfg_data;
        REG_ONE_MIN:  one_min  <= cfg_data;
        REG_ONE_MAX:  one_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // use the first half if it is high, else the second
  assign have_high = first_level | second_level;
  assign dur       = first_level ? first_duration : second_duration;
  assign in_zero   = (dur > zero_min) && (dur < zero_max);
  assign in_one    = (dur > one_min) && (dur < one_max);

  always_comb begin
    cmd.start = frame_start;
    if (!have_high) begin
      cmd.act = ACT_KEEP;
    end else if (in_zero) begin
      cmd.act = ACT_ZERO;
    end else if (in_one) begin
      cmd.act = ACT_ONE;
    end else begin
      cmd.act = ACT_KEEP;
    end
  end

endmodule

/* rtl/dht_queue.sv */
// ----------------------------------------------------------------------------
// dht_queue
// Short command queue between the classifier and the frame assembler.
// ----------------------------------------------------------------------------
module dht_queue #(
  parameter int DEPTH = dht_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dht_pkg::pulse_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output dht_pkg::pulse_cmd_t head
);
  import dht_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pulse_cmd_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

/* rtl/dht_back.sv */
// ----------------------------------------------------------------------------
// dht_back
// Applies pulse commands to the frame bit store, tracks the pulse index and
// packs the result word into the output register at the end of a frame.
// ----------------------------------------------------------------------------
module dht_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  dht_pkg::pulse_cmd_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          humidity_tenths,
  output logic [15:0]          temperature_raw,
  output logic [7:0]           received_checksum,
  output logic                 checksum_ok
);
  import dht_pkg::*;

  logic [PULSES_PER_FRAME-1:0] frame_bits;
  logic [PULSES_PER_FRAME-1:0] frame_bits_next;
  logic [IDX_W-1:0]            pulse_index;
  logic [IDX_W-1:0]            pos;
  logic                        last_pulse;
  logic                        can_load;
  logic                        load;

  logic [7:0] h1, h2, t1, t2, ck;
  logic [9:0] sum;
  logic       ok;

  assign pos        = head.start ? '0 : pulse_index;
  assign last_pulse = (pos == LAST_INDEX);
  assign can_load   = !out_valid || !out_stall;
  // hold the last pulse of a frame until the output register frees up
  assign pop        = !empty && (!last_pulse || can_load);
  assign load       = pop && last_pulse;

  always_comb begin
    frame_bits_next = frame_bits;
    if (head.act != ACT_KEEP) begin
      frame_bits_next[pos] = (head.act == ACT_ONE);
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      h1[7-k] = frame_bits_next[DATA_FIRST + k];
      h2[7-k] = frame_bits_next[DATA_FIRST + 8 + k];
      t1[7-k] = frame_bits_next[DATA_FIRST + 16 + k];
      t2[7-k] = frame_bits_next[DATA_FIRST + 24 + k];
      ck[7-k] = frame_bits_next[DATA_FIRST + 32 + k];
    end
  end

  assign sum = {2'b00, h1} + {2'b00, h2} + {2'b00, t1} + {2'b00, t2};
  assign ok  = (sum[7:0] == ck);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits  <= '0;
      pulse_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        frame_bits  <= frame_bits_next;
        pulse_index <= last_pulse ? '0 : pos + IDX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      humidity_tenths   <= ok ? {h1, h2} : 16'h0000;
      temperature_raw   <= ok ? {t1, t2} : 16'h0000;
      received_checksum <= ck;
      checksum_ok       <= ok;
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    pulse_index <= LAST_INDEX)
    else $error("pulse index out of frame");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    load |=> (pulse_index == '0) && out_valid)
    else $error("index did not wrap at frame end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule

/* rtl/dht22_pulse_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// dht22_pulse_frame_decoder_unit
// Decodes captured single-wire sensor pulse records into humidity,
// temperature and checksum results, one result per 42-pulse frame.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     frame_start, first/second level+duration
//   out      out_valid / out_stall   humidity_tenths, temperature_raw,
//                                    received_checksum, checksum_ok
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pulse record is taken per cycle while in_stall is low; the classifier
// pushes into a short queue and the frame assembler pops one command a cycle
// unless the queue is empty or a last pulse waits on a stalled result. A result
// is registered at the edge where the last pulse of a frame leaves the queue.
// A stalled result holds the last pulse of the next frame in the queue; other
// pulses keep flowing, and in_stall rises only once the queue is full.
// Reset clears the window registers to their defaults, the bit store and the
// pulse index; cfg_ready is always high.
// ----------------------------------------------------------------------------
module dht22_pulse_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = dht_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dht_pkg::DUR_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           frame_start,
  input  logic                           first_level,
  input  logic [dht_pkg::DUR_W-1:0]      first_duration,
  input  logic                           second_level,
  input  logic [dht_pkg::DUR_W-1:0]      second_duration,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    humidity_tenths,
  output logic [15:0]                    temperature_raw,
  output logic [7:0]                     received_checksum,
  output logic                           checksum_ok
);
  import dht_pkg::*;

  pulse_cmd_t cmd;
  pulse_cmd_t head;
  logic       full;
  logic       empty;
  logic       pop;
  logic       push;

  assign in_stall = full;
  assign push     = in_valid && !in_stall;

  dht_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .frame_start     (frame_start),
    .first_level     (first_level),
    .first_duration  (first_duration),
    .second_level    (second_level),
    .second_duration (second_duration),
    .cmd             (cmd)
  );

  dht_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  dht_back u_back (
    .clk               (clk),
    .rst               (rst),
    .empty             (empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .humidity_tenths   (humidity_tenths),
    .temperature_raw   (temperature_raw),
    .received_checksum (received_checksum),
    .checksum_ok       (checksum_ok)
  );

endmodule

/* tb/dht22_pulse_frame_decoder_unit_test.sv */
// ----------------------------------------------------------------------------
// dht22_pulse_frame_decoder_unit_test
// Drives pulse records into the frame decoder and checks every humidity,
// temperature and checksum result against an in-bench decoder. A short
// table of corner frames runs first. Random frames, torn frames and line
// noise follow under several window settings and idle patterns.
// ----------------------------------------------------------------------------
module dht22_pulse_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  localparam int DATA_BITS     = PULSES_PER_FRAME - DATA_FIRST;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEG_PULSES    = 120;
  localparam int SEG_READINGS  = 2;
  localparam int SEGMENTS      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic             start;
    logic             lvl_a;
    logic [DUR_W-1:0] dur_a;
    logic             lvl_b;
    logic [DUR_W-1:0] dur_b;
  } pulse_t;

  typedef struct packed {
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic [7:0]  checksum;
    logic        ok;
  } reading_t;

  typedef enum logic {
    ROW_PULSE,
    ROW_FRAME
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [6:0]           count;
    pulse_t               pulse;
    logic [DATA_BITS-1:0] payload;
    logic                 typed;
    reading_t             want;
  } row_t;

  typedef enum int {
    SHAPE_ZERO,
    SHAPE_ONE,
    SHAPE_RAW,
    SHAPE_NO_HIGH,
    SHAPE_EDGE
  } shape_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 frame_start;
  logic                 first_level;
  logic [DUR_W-1:0]     first_duration;
  logic                 second_level;
  logic [DUR_W-1:0]     second_duration;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          humidity_tenths;
  logic [15:0]          temperature_raw;
  logic [7:0]           received_checksum;
  logic                 checksum_ok;

  // decoder state mirrored in the bench
  logic [DUR_W-1:0] win_zero_min = ZERO_MIN_RESET;
  logic [DUR_W-1:0] win_zero_max = ZERO_MAX_RESET;
  logic [DUR_W-1:0] win_one_min  = ONE_MIN_RESET;
  logic [DUR_W-1:0] win_one_max  = ONE_MAX_RESET;
  logic             stored_bits [PULSES_PER_FRAME];
  int               bit_pos = 0;

  reading_t expected_readings [$];
  row_t     directed_rows [$];
  int       pulses_sent  = 0;
  int       readings_due = 0;
  int       fail_count   = 0;
  int       src_idle_pct = 0;
  int       sink_idle_pct = 0;

  dht22_pulse_frame_decoder_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .frame_start       (frame_start),
    .first_level       (first_level),
    .first_duration    (first_duration),
    .second_level      (second_level),
    .second_duration   (second_duration),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .humidity_tenths   (humidity_tenths),
    .temperature_raw   (temperature_raw),
    .received_checksum (received_checksum),
    .checksum_ok       (checksum_ok)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dht22_pulse_frame_decoder_unit regression: fail");
    $finish;
  end

  function automatic reading_t reading(logic [15:0] h, logic [15:0] t, logic [7:0] c,
                                       logic ok);
    reading_t r;
    r.humidity    = h;
    r.temperature = t;
    r.checksum    = c;
    r.ok          = ok;
    return r;
  endfunction

  function automatic row_t pulse_row(int count, logic start, logic la, int da, logic lb,
                                     int db, logic typed, reading_t want);
    row_t rw;
    rw             = '0;
    rw.kind        = ROW_PULSE;
    rw.count       = 7'(count);
    rw.pulse.start = start;
    rw.pulse.lvl_a = la;
    rw.pulse.dur_a = DUR_W'(da);
    rw.pulse.lvl_b = lb;
    rw.pulse.dur_b = DUR_W'(db);
    rw.typed       = typed;
    rw.want        = want;
    return rw;
  endfunction

  function automatic row_t frame_row(logic [DATA_BITS-1:0] payload, logic typed,
                                     reading_t want);
    row_t rw;
    rw         = '0;
    rw.kind    = ROW_FRAME;
    rw.payload = payload;
    rw.typed   = typed;
    rw.want    = want;
    return rw;
  endfunction

  function automatic bit_act_t classify(logic [DUR_W-1:0] d);
    // zero window is tested first, so it wins where the windows overlap
    if (d > win_zero_min && d < win_zero_max) return ACT_ZERO;
    if (d > win_one_min && d < win_one_max) return ACT_ONE;
    return ACT_KEEP;
  endfunction

  task automatic decode_pulse(input pulse_t p, output logic done, output reading_t r);
    bit_act_t             act;
    logic [DATA_BITS-1:0] data;
    logic [7:0]           sum;
    int                   k;
    done = 1'b0;
    r    = '0;
    if (p.start) bit_pos = 0;
    if (p.lvl_a) act = classify(p.dur_a);
    else if (p.lvl_b) act = classify(p.dur_b);
    else act = ACT_KEEP;
    case (act)
      ACT_ZERO: stored_bits[bit_pos] = 1'b0;
      ACT_ONE:  stored_bits[bit_pos] = 1'b1;
      default: ;
    endcase
    if (bit_pos == PULSES_PER_FRAME - 1) begin
      bit_pos = 0;
      done    = 1'b1;
      for (k = 0; k < DATA_BITS; k++) data[DATA_BITS-1-k] = stored_bits[DATA_FIRST + k];
      sum = data[39:32] + data[31:24] + data[23:16] + data[15:8];
      r.checksum = data[7:0];
      r.ok       = (sum == data[7:0]);
      if (r.ok) begin
        r.humidity    = data[39:24];
        r.temperature = data[23:8];
      end
    end else begin
      bit_pos++;
    end
  endtask

  function automatic logic [DUR_W-1:0] pick_inside(logic [DUR_W-1:0] lo,
                                                   logic [DUR_W-1:0] hi);
    if (int'(hi) > int'(lo) + 1) return DUR_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return DUR_W'($urandom);
  endfunction

  function automatic pulse_t make_pulse(logic start, shape_t shape);
    pulse_t           p;
    logic [DUR_W-1:0] d;
    p.start = start;
    p.lvl_a = 1'($urandom);
    p.dur_a = DUR_W'($urandom);
    p.lvl_b = 1'($urandom);
    p.dur_b = DUR_W'($urandom);
    case (shape)
      SHAPE_ZERO: d = pick_inside(win_zero_min, win_zero_max);
      SHAPE_ONE:  d = pick_inside(win_one_min, win_one_max);
      SHAPE_EDGE: begin
        case ($urandom_range(0, 3))
          0:       d = win_zero_min;
          1:       d = win_zero_max;
          2:       d = win_one_min;
          default: d = win_one_max;
        endcase
      end
      SHAPE_NO_HIGH: begin
        p.lvl_a = 1'b0;
        p.lvl_b = 1'b0;
        return p;
      end
      default: return p;
    endcase
    if ($urandom_range(0, 1) != 0) begin
      p.lvl_a = 1'b1;
      p.dur_a = d;
    end else begin
      p.lvl_a = 1'b0;
      p.lvl_b = 1'b1;
      p.dur_b = d;
    end
    return p;
  endfunction

  task automatic send_pulse(input pulse_t p, input logic typed, input reading_t want);
    logic     done;
    reading_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    frame_start     <= p.start;
    first_level     <= p.lvl_a;
    first_duration  <= p.dur_a;
    second_level    <= p.lvl_b;
    second_duration <= p.dur_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pulses_sent++;
    decode_pulse(p, done, r);
    if (done) begin
      expected_readings.push_back(typed ? want : r);
      readings_due++;
    end
  endtask

  task automatic send_frame(input logic start, input logic [DATA_BITS-1:0] payload,
                            input int corrupt_pct, input int length, input logic typed,
                            input reading_t want);
    shape_t shape;
    int     k;
    for (k = 0; k < length; k++) begin
      if (k < DATA_FIRST) shape = SHAPE_RAW;
      else if ($urandom_range(0, 99) < corrupt_pct)
        shape = shape_t'($urandom_range(SHAPE_RAW, SHAPE_EDGE));
      else shape = payload[PULSES_PER_FRAME-1-k] ? SHAPE_ONE : SHAPE_ZERO;
      send_pulse(make_pulse(start && k == 0, shape), typed, want);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ZERO_MIN: win_zero_min = val;
      REG_ZERO_MAX: win_zero_max = val;
      REG_ONE_MIN:  win_one_min  = val;
      REG_ONE_MAX:  win_one_max  = val;
      default: ;
    endcase
  endtask

  task automatic set_windows(input int zmin, input int zmax, input int omin, input int omax);
    write_reg(REG_ZERO_MIN, DUR_W'(zmin));
    write_reg(REG_ZERO_MAX, DUR_W'(zmax));
    write_reg(REG_ONE_MIN, DUR_W'(omin));
    write_reg(REG_ONE_MAX, DUR_W'(omax));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let every result out and the queue behind it empty before a register write
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
  end

  always @(posedge clk) begin : result_check
    reading_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: humidity %h temperature %h",
               humidity_tenths, temperature_raw);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (humidity_tenths !== want.humidity) begin
          $error("humidity_tenths: expected %h, got %h", want.humidity, humidity_tenths);
          fail_count++;
        end
        if (temperature_raw !== want.temperature) begin
          $error("temperature_raw: expected %h, got %h", want.temperature, temperature_raw);
          fail_count++;
        end
        if (received_checksum !== want.checksum) begin
          $error("received_checksum: expected %h, got %h", want.checksum,
                 received_checksum);
          fail_count++;
        end
        if (checksum_ok !== want.ok) begin
          $error("checksum_ok: expected %b, got %b", want.ok, checksum_ok);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t                 rw;
    pulse_t               p;
    reading_t             none;
    logic [DATA_BITS-1:0] payload;
    logic [7:0]           b [4];
    int                   n, seg, pick, seg_pulses, seg_readings, zmin, omin;

    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    frame_start     = 1'b0;
    first_level     = 1'b0;
    first_duration  = '0;
    second_level    = 1'b0;
    second_duration = '0;
    none            = '0;
    foreach (stored_bits[i]) stored_bits[i] = 1'b0;

    // corner frames under the reset windows
    directed_rows.push_back(pulse_row(42, 1, 0, 32767, 0, 0, 1, reading(0, 0, 8'h00, 1)));
    directed_rows.push_back(pulse_row(42, 1, 1, 75, 0, 32767, 1, reading(0, 0, 8'hFF, 0)));
    // exact window bounds keep the old bits
    directed_rows.push_back(pulse_row(10, 1, 1, 20, 0, 0, 0, none));
    directed_rows.push_back(pulse_row(10, 0, 1, 30, 0, 0, 0, none));
    directed_rows.push_back(pulse_row(11, 0, 1, 70, 0, 0, 0, none));
    directed_rows.push_back(pulse_row(11, 0, 1, 80, 0, 0, 1, reading(0, 0, 8'hFF, 0)));
    // extreme durations; a high first half wins even when out of window
    directed_rows.push_back(pulse_row(21, 1, 0, 0, 1, 32767, 0, none));
    directed_rows.push_back(pulse_row(21, 0, 1, 0, 1, 25, 1, reading(0, 0, 8'hFF, 0)));
    directed_rows.push_back(pulse_row(42, 1, 1, 25, 1, 75, 1, reading(0, 0, 8'h00, 1)));
    // torn frame abandoned by a new start
    directed_rows.push_back(pulse_row(20, 1, 0, 7, 1, 75, 0, none));
    directed_rows.push_back(pulse_row(42, 1, 1, 21, 0, 0, 1, reading(0, 0, 8'h00, 1)));
    // index wraps on its own after the last pulse
    directed_rows.push_back(pulse_row(42, 0, 1, 79, 0, 0, 1, reading(0, 0, 8'hFF, 0)));
    directed_rows.push_back(frame_row(40'h02_8C_80_65_73, 1,
                                      reading(16'h028C, 16'h8065, 8'h73, 1)));
    directed_rows.push_back(frame_row(40'h01_90_00_FA_8C, 1, reading(0, 0, 8'h8C, 0)));
    directed_rows.push_back(frame_row(40'hFF_FF_FF_FF_FC, 1,
                                      reading(16'hFFFF, 16'hFFFF, 8'hFC, 1)));
    directed_rows.push_back(frame_row(40'h12_34_56_78_14, 0, none));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 26;
    sink_idle_pct = 69;
    foreach (directed_rows[i]) begin
      rw = directed_rows[i];
      if (rw.kind == ROW_FRAME) begin
        send_frame(1'b1, rw.payload, 0, PULSES_PER_FRAME, rw.typed, rw.want);
      end else begin
        for (n = 0; n < rw.count; n++) begin
          p = rw.pulse;
          if (n != 0) p.start = 1'b0;
          send_pulse(p, rw.typed, rw.want);
        end
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_idle();
      case (seg)
        1: set_windows(0, 900, 1000, 32767);
        // overlapping windows
        2: set_windows(10, 60, 40, 120);
        // one window below the zero window, zero window at the top
        3: set_windows(32000, 32767, 0, 8);
        4: begin
          zmin = $urandom_range(0, 16000);
          omin = $urandom_range(0, 32000);
          set_windows(zmin, zmin + $urandom_range(2, 400), omin,
                      (omin + $urandom_range(2, 600) > 32767) ? 32767
                                                              : omin + $urandom_range(2, 600));
        end
        5: begin
          write_reg(REG_SPARE_FIRST, DUR_W'($urandom));
          write_reg(REG_SPARE_LAST, DUR_W'($urandom));
          set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, ONE_MIN_RESET, ONE_MAX_RESET);
        end
        default: ;
      endcase
      case (seg / 2)
        0: begin
          src_idle_pct  = 26;
          sink_idle_pct = 69;
        end
        1: begin
          src_idle_pct  = 69;
          sink_idle_pct = 26;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase

      seg_pulses   = pulses_sent;
      seg_readings = readings_due;
      while (pulses_sent - seg_pulses < SEG_PULSES ||
             readings_due - seg_readings < SEG_READINGS) begin
        pick = $urandom_range(0, 99);
        foreach (b[i]) b[i] = 8'($urandom);
        payload = {b[0], b[1], b[2], b[3], 8'(b[0] + b[1] + b[2] + b[3])};
        if ($urandom_range(0, 3) == 0) payload[7:0] = 8'($urandom);
        if (pick < 70) begin
          // start may be left low when the index already sits at zero
          send_frame(bit_pos != 0 || $urandom_range(0, 4) != 0, payload, 8,
                     PULSES_PER_FRAME, 1'b0, none);
        end else if (pick < 85) begin
          send_frame(1'b1, payload, 8, $urandom_range(1, PULSES_PER_FRAME - 1), 1'b0, none);
        end else begin
          for (n = $urandom_range(1, 30); n > 0; n--)
            send_pulse(make_pulse($urandom_range(0, 19) == 0,
                                  shape_t'($urandom_range(SHAPE_ZERO, SHAPE_EDGE))),
                       1'b0, none);
        end
      end
    end

    wait_for_idle();
    if (fail_count == 0) begin
      $display("dht22_pulse_frame_decoder_unit regression: pass");
    end else begin
      $display("dht22_pulse_frame_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
